@@ design/dt_pkg.sv @@
`default_nettype none
package dt_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int SEP_MASK_W  = 35;
    localparam int DISS_MASK_W = 3;
    localparam int CFG_DATA_W  = SEP_MASK_W;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_W       = 32;
    localparam int NUM_PUNCT   = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_SEP_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISS_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ISOLATE   = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int CLS_WS     = 0;
    localparam int CLS_LF     = 1;
    localparam int CLS_TAB    = 2;
    localparam int CLS_ALPHA  = 3;
    localparam int CLS_DIGIT  = 4;
    localparam int CLS_PUNCT0 = 5;

    // Punctuation classes in mask order, starting at mask bit CLS_PUNCT0.
    localparam logic [7:0] PUNCT [NUM_PUNCT] = '{
        8'h21, 8'h3F, 8'h3A, 8'h3B, 8'h2E, 8'h2C, 8'h40, 8'h23, 8'h24, 8'h25,
        8'h5E, 8'h26, 8'h2A, 8'h2D, 8'h2B, 8'h3D, 8'h2F, 8'h5C, 8'h7E, 8'h7C,
        8'h60, 8'h5F, 8'h3C, 8'h3E, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_text_item;

    typedef struct packed {
        logic [OUT_W-1:0] token_offset;
        logic [OUT_W-1:0] token_length;
        logic             last_of_step;
    } t_token_item;

    typedef struct packed {
        logic [OUT_W-1:0] offset;
        logic [OUT_W-1:0] length;
    } t_token;

    // Tokens produced by one byte; tok1 is valid only when two is set.
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_step;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic is_separator(input logic [7:0] c,
                                          input logic [SEP_MASK_W-1:0] m);
        logic hit;
        hit = 1'b0;
        if (m[CLS_WS] && (c == CH_SPACE || c == CH_TAB || c == CH_LF ||
                          c == CH_VT || c == CH_FF || c == CH_CR)) begin
            hit = 1'b1;
        end
        if (m[CLS_LF] && c == CH_LF) begin
            hit = 1'b1;
        end
        if (m[CLS_TAB] && c == CH_TAB) begin
            hit = 1'b1;
        end
        if (m[CLS_ALPHA] && (c inside {[8'h41:8'h5A], [8'h61:8'h7A]})) begin
            hit = 1'b1;
        end
        if (m[CLS_DIGIT] && (c inside {[8'h30:8'h39]})) begin
            hit = 1'b1;
        end
        for (int k = 0; k < NUM_PUNCT; k++) begin
            if (m[CLS_PUNCT0 + k] && c == PUNCT[k]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic is_dissolvable(input logic [7:0] c,
                                            input logic [DISS_MASK_W-1:0] m);
        return (c == CH_SPACE && m[0]) || (c == CH_LF && m[1]) || (c == CH_TAB && m[2]);
    endfunction

endpackage
`default_nettype wire

@@ design/dt_front.sv @@
`default_nettype none
module dt_front #(
    parameter int OFFSET_BITS = dt_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [dt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [dt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                           i_accept,
    input  wire dt_pkg::t_text_item             i_item,
    output logic                                o_push,
    output dt_pkg::t_step                       o_step
);
    import dt_pkg::*;

    logic [SEP_MASK_W-1:0]  r_sep_mask;
    logic [DISS_MASK_W-1:0] r_diss_mask;
    logic                   r_isolate;

    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic                   r_in_tok, n_in_tok;
    logic [OFFSET_BITS-1:0] r_start, n_start;

    logic                   sep, diss, live;
    logic                   e_close, e_iso, e_flush;
    logic                   mid_in;
    logic [OFFSET_BITS-1:0] mid_start;
    t_token                 t_close, t_iso, t_flush;

    function automatic logic [OUT_W-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_mask  <= '0;
            r_diss_mask <= '0;
            r_isolate   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEP_MASK:  r_sep_mask  <= i_cfg_data[SEP_MASK_W-1:0];
                CFG_DISS_MASK: r_diss_mask <= i_cfg_data[DISS_MASK_W-1:0];
                CFG_ISOLATE:   r_isolate   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        live = i_item.text_byte != CH_NUL;
        sep  = is_separator(i_item.text_byte, r_sep_mask);
        diss = is_dissolvable(i_item.text_byte, r_diss_mask);

        e_close = live && (sep || diss) && r_in_tok;
        e_iso   = live && sep && !diss && r_isolate;

        mid_in    = r_in_tok;
        mid_start = r_start;
        if (live) begin
            if (sep || diss) begin
                mid_in = sep && !diss && !r_isolate;
                if (mid_in) begin
                    mid_start = r_pos;
                end
            end else if (!r_in_tok) begin
                mid_in    = 1'b1;
                mid_start = r_pos;
            end
        end
        e_flush = i_item.end_of_text && mid_in;

        t_close.offset = to_out(r_start);
        t_close.length = to_out(r_pos - r_start);
        t_iso.offset   = to_out(r_pos);
        t_iso.length   = OUT_W'(1);
        t_flush.offset = to_out(mid_start);
        t_flush.length = to_out(r_pos + OFFSET_BITS'(1) - mid_start);

        // At most two of the three can fire: isolation leaves no open token to flush.
        o_step.tok0 = e_close ? t_close : (e_iso ? t_iso : t_flush);
        o_step.tok1 = (e_close && e_iso) ? t_iso : t_flush;
        o_step.two  = e_close && (e_iso || e_flush);
        o_push      = i_accept && (e_close || e_iso || e_flush);

        if (i_item.end_of_text) begin
            n_pos    = '0;
            n_in_tok = 1'b0;
            n_start  = '0;
        end else begin
            n_pos    = r_pos + OFFSET_BITS'(1);
            n_in_tok = mid_in;
            n_start  = mid_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_in_tok <= 1'b0;
            r_start  <= '0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_in_tok <= n_in_tok;
            r_start  <= n_start;
        end
    end

endmodule
`default_nettype wire

@@ design/dt_queue.sv @@
`default_nettype none
module dt_queue #(
    parameter int DEPTH = dt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dt_pkg::t_step     i_data,
    input  wire logic              i_pop,
    output dt_pkg::t_step          o_data,
    output dt_pkg::t_queue_status  o_status
);
    import dt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_step          r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_status.full  = r_cnt == CW'(DEPTH);
    assign o_status.empty = r_cnt == '0;
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rp];

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= bump(r_wp);
            end
            if (do_pop) begin
                r_rp <= bump(r_rp);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ design/dt_back.sv @@
`default_nettype none
module dt_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dt_pkg::t_step     i_head,
    input  wire logic              i_empty,
    input  wire logic              i_pop,
    output logic                   o_queue_pop,
    output logic                   o_empty,
    output dt_pkg::t_token_item    o_result
);
    import dt_pkg::*;

    // Set while the second token of a two-token step is on the outputs.
    logic   r_second;
    logic   last;
    t_token cur;

    always_comb begin
        cur                   = r_second ? i_head.tok1 : i_head.tok0;
        last                  = !i_head.two || r_second;
        o_empty               = i_empty;
        o_result.token_offset = cur.offset;
        o_result.token_length = cur.length;
        o_result.last_of_step = last;
        o_queue_pop           = i_pop && !i_empty && last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (i_pop && !i_empty) begin
            r_second <= !last;
        end
    end

endmodule
`default_nettype wire

@@ design/delimiter_tokenizer.sv @@
// delimiter_tokenizer: splits a byte stream into tokens, one byte per transfer.
// Input queue side: drive i_item and raise i_push; the byte is taken on a clock
// edge where o_full is low. i_item.end_of_text marks the last byte of a text and
// flushes any open token; the byte position then restarts at zero.
// Output queue side: while o_empty is low, o_result holds the oldest token
// (offset, length, last_of_step); i_pop takes it.
// Configuration: i_cfg_we with i_cfg_idx 0 (separator classes), 1 (dissolve mask)
// or 2 (isolate) writes i_cfg_data in the same edge; write only while idle.
// A token-making byte is written into the queue register at its transfer edge.
// Throughput: one byte per cycle while o_full is low. Each byte makes zero, one
// or two tokens, and the output side hands out one token per cycle while i_pop
// is high; a byte with two tokens takes two pops. A queue of QUEUE_DEPTH byte
// records sits between the classifier and the output; o_full rises only when it
// is full: a stalled receiver stops input after QUEUE_DEPTH token-making bytes.
// Reset (synchronous, active low) empties the queue, clears position and token
// state, and returns the registers to: no separators, no dissolve, isolate on.
`default_nettype none
module delimiter_tokenizer #(
    parameter int OFFSET_BITS = dt_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = dt_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [dt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [dt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                           i_push,
    input  wire dt_pkg::t_text_item             i_item,
    output logic                                o_full,
    input  wire logic                           i_pop,
    output logic                                o_empty,
    output dt_pkg::t_token_item                 o_result
);
    import dt_pkg::*;

    logic          accept, q_push, q_pop;
    t_step         step_in, step_head;
    t_queue_status q_status;

    assign o_full = q_status.full;
    assign accept = i_push && !q_status.full;

    dt_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_push     (q_push),
        .o_step     (step_in)
    );

    dt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (step_in),
        .i_pop    (q_pop),
        .o_data   (step_head),
        .o_status (q_status)
    );

    dt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (step_head),
        .i_empty     (q_status.empty),
        .i_pop       (i_pop),
        .o_queue_pop (q_pop),
        .o_empty     (o_empty),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

@@ design/dt_checker.sv @@
`default_nettype none
module dt_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 o_full,
    input  wire logic                 i_pop,
    input  wire logic                 o_empty,
    input  wire dt_pkg::t_token_item  o_result
);
    import dt_pkg::*;

    // Reset leaves the block able to take input and with nothing to deliver.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queue not cleared by reset");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_full && o_empty))
        else $error("full and empty at once");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_result)))
        else $error("waiting result changed");

    // The first token of a two-token byte is always followed by its partner.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_result.last_of_step) |=> !o_empty)
        else $error("second token of a byte missing");

    // With QUEUE_DEPTH above one, a transfer into an empty queue cannot leave it full on the next cycle.
    a_no_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !o_full) |=> !o_full)
        else $error("queue filled too fast");

endmodule

bind delimiter_tokenizer dt_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_full   (o_full),
    .i_pop    (i_pop),
    .o_empty  (o_empty),
    .o_result (o_result)
);
`default_nettype wire
